/* rtl/csrt_pkg.sv */
// csrt_pkg: shared types and constants of the snapshot reassembly tracker.
// No dependencies.
`default_nettype none
package csrt_pkg;
  localparam int unsigned SlotN = 16;
  localparam int unsigned SlotW = 4;
  localparam int unsigned ChunkN = 256;
  localparam int unsigned ChunkW = 8;
  localparam logic [15:0] LeadValue = 16'h0005;
  localparam logic [7:0] PacketSize = 8'd65;
  localparam logic [7:0] RecordsMax = 8'd6;

  localparam logic [1:0] RegMsgId = 2'd0;
  localparam logic [1:0] RegVersion = 2'd1;
  localparam logic [1:0] RegMaxChunks = 2'd2;
  localparam logic [1:0] RegStale = 2'd3;

  localparam logic [2:0] StBadHdr = 3'd0;
  localparam logic [2:0] StNotAlly = 3'd1;
  localparam logic [2:0] StOldSeq = 3'd2;
  localparam logic [2:0] StCntErr = 3'd3;
  localparam logic [2:0] StAccept = 3'd4;
  localparam logic [2:0] StDone = 3'd5;
  localparam logic [2:0] StTick = 3'd6;

  // per-slot record held in the slot memory
  typedef struct packed {
    logic        pend_act;
    logic [15:0] pend_seq;
    logic [7:0]  pend_tot;
    logic [7:0]  seen_cnt;
    logic [15:0] done_seq;
    logic        done_vld;
    logic [30:0] upd_time;
    logic        upd_vld;
    logic [7:0]  epoch;
  } slot_rec_t;
endpackage
`default_nettype wire

/* rtl/csrt_bitmap.sv */
// csrt_bitmap: chunk seen bitmap, one 8-bit epoch tag per slot and chunk.
// Depends on csrt_pkg. An entry counts as seen when its tag equals the slot epoch.
`default_nettype none
module csrt_bitmap (
  input  wire logic                                         clk_i,
  input  wire logic                                         rd_en_i,
  input  wire logic [csrt_pkg::SlotW+csrt_pkg::ChunkW-1:0]  rd_addr_i,
  output logic [7:0]                                        rd_tag_o,
  input  wire logic                                         wr_en_i,
  input  wire logic [csrt_pkg::SlotW+csrt_pkg::ChunkW-1:0]  wr_addr_i,
  input  wire logic [7:0]                                   wr_tag_i
);
  logic [7:0] mem [csrt_pkg::SlotN*csrt_pkg::ChunkN];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem[wr_addr_i] <= wr_tag_i;
    if (rd_en_i) rd_tag_o <= mem[rd_addr_i];
  end
endmodule
`default_nettype wire

/* rtl/chunked_snapshot_reassembly_tracker_top.sv */
// chunked_snapshot_reassembly_tracker_top: per-sender snapshot reassembly tracking.
// Depends on csrt_pkg and csrt_bitmap.
//
//  channel | direction | handshake            | payload
//  in      | to block  | in_valid_i/in_stall_o | mode_i .. ally_mask_i
//  out     | from block| out_valid_o/out_stall_i | status_o .. cleared_mask_o
//  cfg     | to block  | cfg_we_i             | cfg_idx_i, cfg_data_i
//
// Packet: slot read, bitmap read, decision, update, then result.
// Tick: a sweep of all 16 slots, each a record read, then clear and write-back if dropped.
// The bitmap uses an 8-bit epoch per slot; a restart or a tick clear bumps it by one.
// Epoch wrap would alias stale tags, so when the epoch wraps to zero a clearing pass
// over all 256 entries of that slot's row runs before the item finishes.
// Reset: control cleared; one pass over all 4096 entries clears the bitmap and, along
// the way, every slot record (epoch set to 1); no item accepted meanwhile.
// The result register holds until taken; the next item is taken once it is free.
`default_nettype none
module chunked_snapshot_reassembly_tracker_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        mode_i,
  input  wire logic [3:0]  sender_slot_i,
  input  wire logic [15:0] lead_bytes_i,
  input  wire logic [7:0]  msg_id_i,
  input  wire logic [7:0]  size_byte_i,
  input  wire logic [7:0]  version_i,
  input  wire logic [15:0] sequence_req_i,
  input  wire logic [7:0]  chunk_index_i,
  input  wire logic [7:0]  chunk_count_i,
  input  wire logic [7:0]  record_count_i,
  input  wire logic [30:0] game_time_i,
  input  wire logic [15:0] ally_mask_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       status_o,
  output logic [3:0]       slot_out_o,
  output logic [15:0]      sequence_out_o,
  output logic [7:0]       chunk_index_out_o,
  output logic [15:0]      cleared_mask_o,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i
);
  typedef enum logic [8:0] {
    S_INIT  = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_PRD   = 9'b000000100,
    S_PBM   = 9'b000001000,
    S_PUPD  = 9'b000010000,
    S_WIPE  = 9'b000100000,
    S_TRD   = 9'b001000000,
    S_TUPD  = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [7:0] msg_id_q, ver_q, maxc_q;
  logic [15:0] stale_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      msg_id_q <= 8'd0; ver_q <= 8'd1; maxc_q <= 8'd200; stale_q <= 16'd300;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        csrt_pkg::RegMsgId:     msg_id_q <= cfg_data_i[7:0];
        csrt_pkg::RegVersion:   ver_q <= cfg_data_i[7:0];
        csrt_pkg::RegMaxChunks: maxc_q <= cfg_data_i[7:0];
        csrt_pkg::RegStale:     stale_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // slot record memory
  csrt_pkg::slot_rec_t smem [csrt_pkg::SlotN];
  csrt_pkg::slot_rec_t srd_q, swr_d;
  logic sre, swe;
  logic [3:0] sra, swa;
  always_ff @(posedge clk_i) begin
    if (swe) smem[swa] <= swr_d;
    if (sre) srd_q <= smem[sra];
  end

  // bitmap
  logic bre, bwe;
  logic [11:0] bra, bwa;
  logic [7:0] btag, bwt;
  csrt_bitmap u_bm (
    .clk_i(clk_i), .rd_en_i(bre), .rd_addr_i(bra), .rd_tag_o(btag),
    .wr_en_i(bwe), .wr_addr_i(bwa), .wr_tag_i(bwt)
  );

  // captured item
  logic mode_q;
  logic [3:0] slot_q;
  logic [15:0] seq_q, ally_q;
  logic [7:0] idx_q, cnt_q;
  logic [30:0] now_q;
  logic hdr_bad_q;

  // work registers
  logic [11:0] cnt12_q, cnt12_d;   // init / wipe counter
  logic [3:0] tcnt_q, tcnt_d;      // tick sweep counter
  logic [15:0] mask_q, mask_d;
  csrt_pkg::slot_rec_t rec_q, rec_d; // modified packet or tick record
  logic [2:0] st_q, st_d;          // packet status pending after wipe, or tick drop flag
  logic res_v_q, res_v_d;
  logic [2:0] r_st_q, r_st_d;
  logic [3:0] r_slot_q, r_slot_d;
  logic [15:0] r_seq_q, r_seq_d, r_mask_q, r_mask_d;
  logic [7:0] r_idx_q, r_idx_d;

  logic accept;
  assign in_stall_o = !(state_q == S_IDLE && !res_v_q);
  assign accept = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= mode_i; slot_q <= sender_slot_i; seq_q <= sequence_req_i;
      ally_q <= ally_mask_i; idx_q <= chunk_index_i; cnt_q <= chunk_count_i;
      now_q <= game_time_i;
      hdr_bad_q <= lead_bytes_i != csrt_pkg::LeadValue || msg_id_i != msg_id_q ||
                   size_byte_i != csrt_pkg::PacketSize || version_i != ver_q ||
                   chunk_count_i == 8'd0 || chunk_count_i > maxc_q ||
                   chunk_index_i >= chunk_count_i || record_count_i > csrt_pkg::RecordsMax;
    end
  end

  // packet decision from the read slot record and bitmap tag
  csrt_pkg::slot_rec_t pr;
  logic [15:0] diff;
  logic restart, seen, old;
  logic [2:0] pst;
  always_comb begin
    pr = srd_q;
    pst = csrt_pkg::StAccept;
    diff = seq_q - srd_q.done_seq;
    old = srd_q.done_vld && seq_q != srd_q.done_seq && diff[15];
    restart = !srd_q.pend_act || srd_q.pend_seq != seq_q;
    seen = 1'b0;
    if (hdr_bad_q) pst = csrt_pkg::StBadHdr;
    else if (!ally_q[slot_q]) pst = csrt_pkg::StNotAlly;
    else if (old) pst = csrt_pkg::StOldSeq;
    else begin
      if (restart) begin
        pr.pend_act = 1'b1; pr.pend_seq = seq_q; pr.pend_tot = cnt_q;
        pr.seen_cnt = 8'd0; pr.epoch = srd_q.epoch + 8'd1;
      end else seen = btag == srd_q.epoch;
      if (pr.pend_tot != cnt_q) pst = csrt_pkg::StCntErr;
      else begin
        if (!seen) pr.seen_cnt = pr.seen_cnt + 8'd1;
        // epoch kept; the next packet restarts and bumps it
        if (pr.seen_cnt == pr.pend_tot) begin
          pst = csrt_pkg::StDone;
          pr.done_seq = seq_q; pr.done_vld = 1'b1; pr.upd_time = now_q; pr.upd_vld = 1'b1;
          pr.pend_act = 1'b0; pr.pend_seq = 16'd0; pr.pend_tot = 8'd0; pr.seen_cnt = 8'd0;
        end
      end
    end
  end

  // tick decision
  csrt_pkg::slot_rec_t tr;
  logic [31:0] age;
  logic drop;
  always_comb begin
    age = {1'b0, now_q} - {1'b0, srd_q.upd_time};
    drop = !ally_q[tcnt_q] ||
           (srd_q.upd_vld && now_q >= srd_q.upd_time && age > {16'd0, stale_q});
    tr = '0;
    tr.epoch = srd_q.epoch + 8'd1;
  end

  always_comb begin
    state_d = state_q;
    cnt12_d = cnt12_q; tcnt_d = tcnt_q; mask_d = mask_q; rec_d = rec_q; st_d = st_q;
    res_v_d = res_v_q && out_stall_i;
    r_st_d = r_st_q; r_slot_d = r_slot_q; r_seq_d = r_seq_q; r_idx_d = r_idx_q;
    r_mask_d = r_mask_q;
    sre = 1'b0; sra = slot_q; swe = 1'b0; swa = slot_q; swr_d = rec_q;
    bre = 1'b0; bra = {slot_q, idx_q}; bwe = 1'b0; bwa = {slot_q, idx_q}; bwt = 8'd0;
    unique case (state_q)
      S_INIT: begin
        bwe = 1'b1; bwa = cnt12_q; bwt = 8'd0;
        swe = 1'b1; swa = cnt12_q[3:0]; swr_d = '0;
        swr_d.epoch = 8'd1;
        cnt12_d = cnt12_q + 12'd1;
        if (cnt12_q == 12'hFFF) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          sre = 1'b1; sra = 4'd0;
          if (mode_i) begin
            tcnt_d = 4'd0; mask_d = 16'd0; state_d = S_TRD;
          end else begin
            sra = sender_slot_i; state_d = S_PRD;
          end
        end
      end
      S_PRD: begin
        bre = 1'b1; state_d = S_PBM;
      end
      S_PBM: begin
        rec_d = pr; st_d = pst; state_d = S_PUPD;
      end
      S_PUPD: begin
        if (st_q == csrt_pkg::StAccept || st_q == csrt_pkg::StDone ||
            st_q == csrt_pkg::StCntErr) begin
          swe = 1'b1; swr_d = rec_q;
          if (rec_q.epoch == 8'd0) begin
            swr_d.epoch = 8'd1;
          end
        end
        if (st_q == csrt_pkg::StAccept) begin
          bwe = 1'b1; bwt = rec_q.epoch;
        end
        if ((st_q == csrt_pkg::StAccept || st_q == csrt_pkg::StDone ||
             st_q == csrt_pkg::StCntErr) && rec_q.epoch == 8'd0) begin
          cnt12_d = 12'd0; state_d = S_WIPE;
        end else state_d = S_OUT;
      end
      S_WIPE: begin
        // row clear after epoch wrap; accepted chunk's entry rewritten with tag 1 as the pass reaches it
        bwe = 1'b1; bwa = {slot_q, cnt12_q[7:0]};
        bwt = (st_q == csrt_pkg::StAccept && cnt12_q[7:0] == idx_q) ? 8'd1 : 8'd0;
        cnt12_d = cnt12_q + 12'd1;
        if (cnt12_q[7:0] == 8'hFF) state_d = S_OUT;
      end
      S_TRD: begin
        // srd_q holds slot tcnt_q
        if (drop) begin
          swe = 1'b1; swa = tcnt_q; swr_d = tr;
          if (tr.epoch == 8'd0) swr_d.epoch = 8'd1;
          mask_d = mask_q | (16'd1 << tcnt_q);
        end
        state_d = S_TUPD;
        rec_d = tr; st_d = {2'b00, drop};
      end
      S_TUPD: begin
        // epoch wrap on a tick clear: wipe that row first
        if (st_q[0] && rec_q.epoch == 8'd0) begin
          bwe = 1'b1; bwa = {tcnt_q, cnt12_q[7:0]}; bwt = 8'd0;
          cnt12_d = cnt12_q + 12'd1;
          if (cnt12_q[7:0] == 8'hFF) begin
            cnt12_d = 12'd0; st_d = 3'd0;
          end
        end else if (tcnt_q == 4'd15) begin
          r_st_d = csrt_pkg::StTick; r_slot_d = 4'd0; r_seq_d = 16'd0; r_idx_d = 8'd0;
          r_mask_d = mask_q; res_v_d = 1'b1; state_d = S_IDLE;
        end else begin
          tcnt_d = tcnt_q + 4'd1; sre = 1'b1; sra = tcnt_d; state_d = S_TRD;
        end
      end
      S_OUT: begin
        r_st_d = st_q; r_slot_d = slot_q; r_mask_d = 16'd0;
        if (st_q == csrt_pkg::StAccept || st_q == csrt_pkg::StDone) begin
          r_seq_d = seq_q; r_idx_d = idx_q;
        end else begin
          r_seq_d = 16'd0; r_idx_d = 8'd0;
        end
        res_v_d = 1'b1; state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT; cnt12_q <= 12'd0; res_v_q <= 1'b0; tcnt_q <= 4'd0;
    end else begin
      state_q <= state_d; cnt12_q <= cnt12_d; res_v_q <= res_v_d; tcnt_q <= tcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mask_q <= mask_d; rec_q <= rec_d; st_q <= st_d;
    r_st_q <= r_st_d; r_slot_q <= r_slot_d; r_seq_q <= r_seq_d;
    r_idx_q <= r_idx_d; r_mask_q <= r_mask_d;
  end

  assign out_valid_o = res_v_q;
  assign status_o = r_st_q;
  assign slot_out_o = r_slot_q;
  assign sequence_out_o = r_seq_q;
  assign chunk_index_out_o = r_idx_q;
  assign cleared_mask_o = r_mask_q;
endmodule
`default_nettype wire
